// ===== src/mpc_pkg.sv =====
package mpc_pkg;

    // Fixed field widths of the ports
    localparam int FRAME_W = 11;
    localparam int PIX_W   = 8;
    localparam int XY_W    = 18;
    localparam int COUNT_W = 21;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MATCH  = 2'd2;

    localparam logic [FRAME_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [FRAME_W-1:0] HEIGHT_RESET = 11'd1024;
    localparam logic [PIX_W-1:0]   MATCH_RESET  = 8'd0;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_LOAD_X,
        ST_DIV_X,
        ST_LOAD_Y,
        ST_DIV_Y,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [FRAME_W-1:0] width;
        logic [FRAME_W-1:0] height;
        logic [PIX_W-1:0]   match;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic load_x;
        logic save_x;
        logic load_y;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic empty;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage

// ===== src/mpc_ctrl.sv =====
module mpc_ctrl
    import mpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (i_in_valid && i_status.last) begin
                    n_state = ST_LOAD_X;
                end
            end
            ST_LOAD_X: begin
                n_state = i_status.empty ? ST_DONE : ST_DIV_X;
            end
            ST_DIV_X: begin
                if (i_status.div_done) begin
                    n_state = ST_LOAD_Y;
                end
            end
            ST_LOAD_Y: begin
                n_state = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_RUN: begin
                o_in_stall  = 1'b0;
                o_cmd.take  = i_in_valid;
            end
            ST_LOAD_X: o_cmd.load_x = 1'b1;
            ST_DIV_X: begin
                o_cmd.step   = 1'b1;
                o_cmd.save_x = i_status.div_done;
            end
            ST_LOAD_Y: o_cmd.load_y = 1'b1;
            ST_DIV_Y:  o_cmd.step   = 1'b1;
            ST_DONE:   o_cmd.out_load = !i_status.out_busy;
            default: begin
                o_cmd      = '0;
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/mpc_dp.sv =====
module mpc_dp
    import mpc_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int FRACTION_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    input  logic [PIX_W-1:0]   i_pixel_value,
    input  logic               i_out_stall,
    output t_status            o_status,
    output logic               o_out_valid,
    output logic [XY_W-1:0]    o_centroid_x_fixed,
    output logic [XY_W-1:0]    o_centroid_y_fixed,
    output logic [COUNT_W-1:0] o_match_count,
    output logic               o_no_match
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WEW    = ($clog2(MAX_WIDTH + 1) > FRAME_W) ?
                            $clog2(MAX_WIDTH + 1) : FRAME_W;
    localparam int HEW    = ($clog2(MAX_HEIGHT + 1) > FRAME_W) ?
                            $clog2(MAX_HEIGHT + 1) : FRAME_W;
    localparam int PIXN_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CSUM_W = COL_W + PIXN_W;
    localparam int RSUM_W = ROW_W + PIXN_W;
    localparam int SUM_W  = (CSUM_W > RSUM_W) ? CSUM_W : RSUM_W;
    localparam int DW     = SUM_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DW + 1);

    localparam logic [WEW-1:0] MAX_W_E = WEW'(MAX_WIDTH);
    localparam logic [HEW-1:0] MAX_H_E = HEW'(MAX_HEIGHT);

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CSUM_W-1:0]  r_csum;
    logic [RSUM_W-1:0]  r_rsum;
    logic [COUNT_W-1:0] r_cnt;

    logic [CSUM_W-1:0]  r_snap_csum;
    logic [RSUM_W-1:0]  r_snap_rsum;
    logic [COUNT_W-1:0] r_snap_cnt;

    logic [DW-1:0]      r_dvd;
    logic [COUNT_W-1:0] r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [XY_W-1:0]    r_qx;

    logic               r_out_valid;
    logic [XY_W-1:0]    r_out_x;
    logic [XY_W-1:0]    r_out_y;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_none;

    logic [WEW-1:0]     w_eff;
    logic [HEW-1:0]     h_eff;
    logic [WEW-1:0]     col_inc;
    logic [HEW-1:0]     row_inc;
    logic               row_end;
    logic               frame_end;
    logic               hit;
    logic [CSUM_W-1:0]  n_csum;
    logic [RSUM_W-1:0]  n_rsum;
    logic [COUNT_W-1:0] n_cnt;

    logic [COUNT_W:0]   rem_shift;
    logic               rem_ge;
    logic [COUNT_W:0]   rem_diff;
    logic               empty;

    // Clamp frame size into the supported range
    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = WEW'(1);
        end else if (WEW'(i_cfg.width) > MAX_W_E) begin
            w_eff = MAX_W_E;
        end else begin
            w_eff = WEW'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h_eff = HEW'(1);
        end else if (HEW'(i_cfg.height) > MAX_H_E) begin
            h_eff = MAX_H_E;
        end else begin
            h_eff = HEW'(i_cfg.height);
        end
    end

    // Position and match for the current pixel
    assign col_inc   = WEW'(r_col) + WEW'(1);
    assign row_inc   = HEW'(r_row) + HEW'(1);
    assign row_end   = (col_inc >= w_eff);
    assign frame_end = row_end && (row_inc >= h_eff);
    assign hit       = (i_pixel_value == i_cfg.match);
    assign n_csum    = r_csum + (hit ? CSUM_W'(r_col) : '0);
    assign n_rsum    = r_rsum + (hit ? RSUM_W'(r_row) : '0);
    assign n_cnt     = r_cnt + (hit ? COUNT_W'(1) : '0);

    // Accumulate sums, hold a snapshot at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_csum <= '0;
            r_rsum <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.take) begin
            if (frame_end) begin
                r_col  <= '0;
                r_row  <= '0;
                r_csum <= '0;
                r_rsum <= '0;
                r_cnt  <= '0;
            end else begin
                r_csum <= n_csum;
                r_rsum <= n_rsum;
                r_cnt  <= n_cnt;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= ROW_W'(row_inc);
                end else begin
                    r_col <= COL_W'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && frame_end) begin
            r_snap_csum <= n_csum;
            r_snap_rsum <= n_rsum;
            r_snap_cnt  <= n_cnt;
        end
    end

    assign empty = (r_snap_cnt == '0);

    // Restoring divider: one quotient bit per cycle, shared by both axes
    assign rem_shift = {r_rem, r_dvd[DW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_snap_cnt});
    assign rem_diff  = rem_shift - {1'b0, r_snap_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load_x || i_cmd.load_y) begin
            r_step <= STEP_W'(DW);
        end else if (i_cmd.step && (r_step != '0)) begin
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_dvd <= DW'(r_snap_csum) << FRACTION_BITS;
            r_rem <= '0;
        end else if (i_cmd.load_y) begin
            r_dvd <= DW'(r_snap_rsum) << FRACTION_BITS;
            r_rem <= '0;
        end else if (i_cmd.step && (r_step != '0)) begin
            r_dvd <= {r_dvd[DW-2:0], rem_ge};
            r_rem <= rem_ge ? COUNT_W'(rem_diff) : COUNT_W'(rem_shift);
        end
    end

    // Hold the column quotient while the row is divided
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_x) begin
            r_qx <= XY_W'(r_dvd);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x    <= empty ? '0 : r_qx;
            r_out_y    <= empty ? '0 : XY_W'(r_dvd);
            r_out_cnt  <= r_snap_cnt;
            r_out_none <= empty;
        end
    end

    assign o_status.last     = frame_end;
    assign o_status.empty    = empty;
    assign o_status.div_done = (r_step == '0);
    assign o_status.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_centroid_x_fixed = r_out_x;
    assign o_centroid_y_fixed = r_out_y;
    assign o_match_count      = r_out_cnt;
    assign o_no_match         = r_out_none;

endmodule

// ===== src/matched_pixel_centroid_core.sv =====
// Centroid of the pixels that equal a match value. Pixels enter one word per
// clock in raster order; column and row follow from the frame width and height
// registers. Within a frame the input takes a pixel every cycle. After a
// frame's last pixel the input stalls while one shared restoring divider
// produces the mean column and then the mean row, one quotient bit per cycle,
// on a dividend of DW bits: DW = log2 of the larger of MAX_WIDTH and
// MAX_HEIGHT plus log2(MAX_WIDTH * MAX_HEIGHT + 1) plus FRACTION_BITS, each
// log2 rounded up. A frame with no match skips the division. The stall
// also lasts while the previous result still waits in the output register.
// Coordinates are unsigned fixed point, truncated; a frame with no match
// sets no_match and gives zero coordinates.
module matched_pixel_centroid_core
    import mpc_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int FRACTION_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PIX_W-1:0]   i_pixel_value,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [XY_W-1:0]    o_centroid_x_fixed,
    output logic [XY_W-1:0]    o_centroid_y_fixed,
    output logic [COUNT_W-1:0] o_match_count,
    output logic               o_no_match
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RESET;
            r_cfg.height <= HEIGHT_RESET;
            r_cfg.match  <= MATCH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_cfg.width  <= pwdata[FRAME_W-1:0];
                REG_HEIGHT: r_cfg.height <= pwdata[FRAME_W-1:0];
                REG_MATCH:  r_cfg.match  <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = APB_DW'(r_cfg.width);
            REG_HEIGHT: prdata = APB_DW'(r_cfg.height);
            REG_MATCH:  prdata = APB_DW'(r_cfg.match);
            default:    prdata = '0;
        endcase
    end

    mpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mpc_dp #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (cmd),
        .i_pixel_value      (i_pixel_value),
        .i_out_stall        (i_out_stall),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .o_centroid_x_fixed (o_centroid_x_fixed),
        .o_centroid_y_fixed (o_centroid_y_fixed),
        .o_match_count      (o_match_count),
        .o_no_match         (o_no_match)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import mpc_pkg::*;

    localparam int MAX_SIDE = 1024;
    localparam int FRAC     = 8;
    localparam int SETTLE   = 128;
    localparam int DRAIN    = 50000;

    typedef struct packed {
        logic [XY_W-1:0]    x;
        logic [XY_W-1:0]    y;
        logic [COUNT_W-1:0] count;
        logic               no_hit;
    } t_centroid;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [PIX_W-1:0]   i_pixel_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [XY_W-1:0]    o_centroid_x_fixed;
    logic [XY_W-1:0]    o_centroid_y_fixed;
    logic [COUNT_W-1:0] o_match_count;
    logic               o_no_match;

    matched_pixel_centroid_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_pixel_value      (i_pixel_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_centroid_x_fixed (o_centroid_x_fixed),
        .o_centroid_y_fixed (o_centroid_y_fixed),
        .o_match_count      (o_match_count),
        .o_no_match         (o_no_match)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the block's registers and frame accumulators
    logic [FRAME_W-1:0] cfg_width  = WIDTH_RESET;
    logic [FRAME_W-1:0] cfg_height = HEIGHT_RESET;
    logic [PIX_W-1:0]   cfg_match  = MATCH_RESET;
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;
    logic [63:0]        col_sum = '0;
    logic [63:0]        row_sum = '0;
    logic [COUNT_W-1:0] hit_total = '0;

    logic [PIX_W-1:0] pixel_q[$];
    t_centroid        centroid_q[$];

    int  pixels_queued = 0;
    int  pixels_taken = 0;
    int  words_checked = 0;
    int  errors = 0;
    int  reg_writes = 0;
    bit  quiet = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    logic [15:0] stall_pat = '0;
    logic [3:0]  stall_step = '0;

    function automatic int unsigned used_size(input logic [FRAME_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return 32'(v);
    endfunction

    function automatic logic [PIX_W-1:0] miss_of(input logic [PIX_W-1:0] m);
        return m + PIX_W'($urandom_range(1, 255));
    endfunction

    // Advance the frame position by one pixel; queue a centroid at frame end
    task automatic centroid_step(input logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        logic [63:0] cx;
        logic [63:0] cy;
        t_centroid   r;
        w = used_size(cfg_width);
        h = used_size(cfg_height);
        if (pix == cfg_match) begin
            col_sum   = col_sum + col_pos;
            row_sum   = row_sum + row_pos;
            hit_total = hit_total + 1'b1;
        end
        if (col_pos + 1 < w) begin
            col_pos++;
        end else begin
            col_pos = 0;
            if (row_pos + 1 < h) begin
                row_pos++;
            end else begin
                if (hit_total == 0) begin
                    r = '{x: '0, y: '0, count: '0, no_hit: 1'b1};
                end else begin
                    cx = (col_sum << FRAC) / hit_total;
                    cy = (row_sum << FRAC) / hit_total;
                    r = '{x: cx[XY_W-1:0], y: cy[XY_W-1:0], count: hit_total, no_hit: 1'b0};
                end
                centroid_q.push_back(r);
                row_pos   = 0;
                col_sum   = '0;
                row_sum   = '0;
                hit_total = '0;
            end
        end
    endtask

    // Pixel driver: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin : driver
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                centroid_step(i_pixel_value);
                pixels_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    i_in_valid    <= 1'b1;
                    i_pixel_value <= pixel_q.pop_front();
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = quiet ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted word, then drive the stall pattern
    always @(posedge i_clk) begin : monitor
        t_centroid want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                words_checked++;
                if (centroid_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: x=%0d y=%0d count=%0d no_match=%0b",
                                 o_centroid_x_fixed, o_centroid_y_fixed, o_match_count,
                                 o_no_match);
                end else begin
                    want = centroid_q.pop_front();
                    if (o_centroid_x_fixed !== want.x || o_centroid_y_fixed !== want.y ||
                        o_match_count !== want.count || o_no_match !== want.no_hit) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp x=%0d y=%0d count=%0d no_match=%0b, ",
                                      "got x=%0d y=%0d count=%0d no_match=%0b"},
                                     want.x, want.y, want.count, want.no_hit,
                                     o_centroid_x_fixed, o_centroid_y_fixed,
                                     o_match_count, o_no_match);
                    end
                end
            end
            if (stall_step == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '0;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom & $urandom);
                    default: stall_pat = 16'hFFF0;
                endcase
                if (quiet) stall_pat = '0;
            end
            i_out_stall <= stall_pat[stall_step];
            stall_step = stall_step + 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = val[FRAME_W-1:0];
            REG_HEIGHT: cfg_height = val[FRAME_W-1:0];
            REG_MATCH:  cfg_match  = val[PIX_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] v);
        pixel_q.push_back(v);
        pixels_queued++;
    endtask

    // Hold until every word is taken and every centroid returned, then settle
    task automatic wait_idle();
        while (pixels_taken != pixels_queued || centroid_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          phase;
        int          frames;
        int          mode;
        int          n;
        int          rand_items;
        int unsigned w;
        int unsigned h;
        logic [PIX_W-1:0] m;
        logic [PIX_W-1:0] v;
        phase      = 0;
        rand_items = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 frames: mixed, empty and full match sets
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        write_reg(REG_MATCH, 32'hFF);
        push_pixel(8'hFF); push_pixel(8'h00); push_pixel(8'hFF);
        push_pixel(8'h55); push_pixel(8'hAA); push_pixel(8'hFF);
        push_pixel(8'h00); push_pixel(8'h01); push_pixel(8'h80);
        push_pixel(8'hFE); push_pixel(8'h7F); push_pixel(8'h00);
        repeat (6) push_pixel(8'hFF);
        wait_idle();

        // Zero sizes act as 1x1 frames
        write_reg(REG_MATCH, 32'h00);
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        wait_idle();

        // Shrink width, then height, in the middle of a frame
        write_reg(REG_MATCH, 32'h3C);
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 3);
        push_pixel(8'h3C); push_pixel(8'h00); push_pixel(8'h3C);
        push_pixel(8'h3C); push_pixel(8'hFF);
        wait_idle();
        write_reg(REG_WIDTH, 2);
        push_pixel(8'h3C);
        push_pixel(8'h3C);
        wait_idle();
        write_reg(REG_HEIGHT, 2);
        push_pixel(8'h3C);
        wait_idle();

        // Widest row (oversized width register) and tallest column,
        // one hit at the far end of each
        m = PIX_W'($urandom);
        write_reg(REG_MATCH, 32'(m));
        write_reg(REG_WIDTH, 32'd2047);
        write_reg(REG_HEIGHT, 1);
        for (n = 0; n < MAX_SIDE; n++) push_pixel(n == MAX_SIDE - 1 ? m : miss_of(m));
        wait_idle();
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, MAX_SIDE);
        for (n = 0; n < MAX_SIDE; n++) push_pixel(n == MAX_SIDE - 1 ? m : miss_of(m));
        wait_idle();

        // Random phases of small frames, some ending mid-frame
        while (rand_items < 500) begin
            phase++;
            quiet = (phase % 4 == 0);
            if (phase == 1 || $urandom_range(0, 3) != 0)
                write_reg(REG_WIDTH, $urandom_range(0, 6));
            if (phase == 1 || $urandom_range(0, 3) != 0)
                write_reg(REG_HEIGHT, $urandom_range(0, 4));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_MATCH, $urandom);
            w = used_size(cfg_width);
            h = used_size(cfg_height);
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
                mode = $urandom_range(0, 9);
                for (n = 0; n < w * h; n++) begin
                    case (mode)
                        0, 1:       v = PIX_W'($urandom);
                        2, 3, 4, 5: v = $urandom_range(0, 1) ? cfg_match : PIX_W'($urandom);
                        6, 7:       v = cfg_match;
                        default:    v = ($urandom_range(0, 7) == 0) ? cfg_match
                                                                    : miss_of(cfg_match);
                    endcase
                    push_pixel(v);
                    rand_items++;
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                for (n = $urandom_range(1, 3); n > 0; n--) begin
                    push_pixel(PIX_W'($urandom));
                    rand_items++;
                end
            end
            wait_idle();
        end
        quiet = 1'b0;

        // Bounded drain, then count anything still outstanding
        for (n = 0; n < DRAIN && (pixels_taken != pixels_queued || centroid_q.size() != 0);
             n++)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        errors += centroid_q.size() + (pixels_queued - pixels_taken);

        $display("Streamed %0d pixels over %0d register writes and checked %0d centroid words",
                 pixels_taken, reg_writes, words_checked);
        $display("Frames from 1x1 to 1024 wide/tall, empty/full/partial; %0d errors", errors);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #(4 * 400000);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
